/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the circular deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int DATA_W = 32;

	// Operation codes.
	localparam logic [1:0] OP_INS_FRONT = 2'd0;
	localparam logic [1:0] OP_INS_REAR  = 2'd1;
	localparam logic [1:0] OP_REM_FRONT = 2'd2;
	localparam logic [1:0] OP_REM_REAR  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [1:0]               status;
	} out_t;

	// Decision of the controller for one request.
	typedef struct packed {
		logic       we;
		logic       re;
		logic [1:0] status;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/cdq_mem.sv */
// ----------------------------------------------------------------------------
// cdq_mem
// Element store: one write and one read through a shared address, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_mem #(
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic                             re,
	input  wire logic [AW-1:0]                    addr,
	input  wire logic signed [cdq_pkg::DATA_W-1:0] wdata,
	output logic signed [cdq_pkg::DATA_W-1:0]      rdata
);

	logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// The read data holds until the next read, so a stalled result keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head, tail and occupancy registers; decides each request's memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl #(
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [1:0]    op,
	output cdq_pkg::cmd_t      cmd,
	output logic [AW-1:0]      addr
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);
	localparam logic [OCC_W-1:0] ONE_OCC  = OCC_W'(1);

	logic [AW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [AW-1:0]    head_dec, head_inc, tail_dec, tail_inc;

	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);

	always_comb begin
		cmd    = '{we: 1'b0, re: 1'b0, status: cdq_pkg::ST_DONE};
		addr   = '0;
		head_d = head_q;
		tail_d = tail_q;
		occ_d  = occ_q;
		unique case (op) inside
			cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
				if (occ_q == FULL_OCC) begin
					cmd.status = cdq_pkg::ST_FULL;
				end else begin
					cmd.we = 1'b1;
					occ_d  = occ_q + ONE_OCC;
					// An insert into an empty deque always lands in entry zero.
					if (occ_q == '0) begin
						head_d = '0;
						tail_d = '0;
						addr   = '0;
					end else if (op == cdq_pkg::OP_INS_FRONT) begin
						head_d = head_dec;
						addr   = head_dec;
					end else begin
						tail_d = tail_inc;
						addr   = tail_inc;
					end
				end
			end
			cdq_pkg::OP_REM_FRONT, cdq_pkg::OP_REM_REAR: begin
				if (occ_q == '0) begin
					cmd.status = cdq_pkg::ST_EMPTY;
				end else begin
					cmd.re = 1'b1;
					occ_d  = occ_q - ONE_OCC;
					addr   = (op == cdq_pkg::OP_REM_FRONT) ? head_q : tail_q;
					if (occ_q == ONE_OCC) begin
						head_d = '0;
						tail_d = '0;
					end else if (op == cdq_pkg::OP_REM_FRONT) begin
						head_d = head_inc;
					end else begin
						tail_d = tail_dec;
					end
				end
			end
			default: begin
				cmd.status = cdq_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			occ_q  <= occ_d;
		end
	end

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy exceeds depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty deque with nonzero pointers");

	a_one_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == ONE_OCC) |-> (head_q == tail_q))
		else $error("single element with head and tail apart");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> (occ_q == $past(occ_q) && head_q == $past(head_q)))
		else $error("pointers moved without a request");

endmodule

`default_nettype wire

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed 32-bit words in a circular memory.
// ----------------------------------------------------------------------------
// Each request inserts at the front or rear or removes from the front or rear
// and yields exactly one response: the removed word with status done, zero
// with status done for an insert, or zero with status full or empty when the
// request is refused. One request is taken per cycle when responses are taken
// as they come; stage 1 registers the pointer update and memory access, and
// the response register takes the registered memory read. A stalled response
// holds back the next request only once the stage between the memory and the
// response register is occupied as well.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire cdq_pkg::in_t    req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output cdq_pkg::out_t        rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cdq_pkg::cmd_t                 cmd;
	logic [AW-1:0]                 addr;
	logic                          accept;
	logic                          s1_adv;
	logic                          vld_s1;
	logic                          rd_s1;
	logic [1:0]                    status_s1;
	logic signed [cdq_pkg::DATA_W-1:0] rdata;

	assign s1_adv    = !rsp_valid || !rsp_stall;
	assign req_stall = vld_s1 && !s1_adv;
	assign accept    = req_valid && !req_stall;

	cdq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (req.op),
		.cmd    (cmd),
		.addr   (addr)
	);

	cdq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (accept && cmd.we),
		.re    (accept && cmd.re),
		.addr  (addr),
		.wdata (req.value),
		.rdata (rdata)
	);

	// Stage 1 waits for the memory read; its payload needs no reset.
	// An empty stage 1 takes a request even while the response is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_adv || !vld_s1) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= cmd.re;
			status_s1 <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && vld_s1) begin
			rsp.data   <= rd_s1 ? rdata : '0;
			rsp.status <= status_s1;
		end
	end

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_adv) |=> vld_s1)
		else $error("stage 1 dropped a pending response");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a blocked response");

	a_rd_zero_status: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && rd_s1) |-> (status_s1 == cdq_pkg::ST_DONE))
		else $error("read issued for a refused request");

endmodule

`default_nettype wire

/* test/cdq_response_check.sv */
// ----------------------------------------------------------------------------
// cdq_response_check
// Watches both channels of the circular deque and checks every response.
// ----------------------------------------------------------------------------
// Each accepted request runs through a local deque model that predicts its
// response. The predictions wait in order and each accepted response is
// compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module cdq_response_check #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  cdq_pkg::in_t   req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  cdq_pkg::out_t  rsp,
	output int             fail_count,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	logic signed [DATA_W-1:0] deque_words [DEPTH];
	int                       front_idx;
	int                       rear_idx;
	int                       fill_level;
	out_t                     predicted_rsp_q [$];
	int                       error_tally = 0;

	assign fail_count = error_tally;

	// Applies one request to the model and returns the response it causes.
	function automatic out_t predict_response(in_t r);
		out_t o;
		o.data   = '0;
		o.status = ST_DONE;
		case (r.op)
			OP_INS_FRONT, OP_INS_REAR: begin
				if (fill_level == DEPTH) begin
					o.status = ST_FULL;
				end else begin
					// An insert into an empty deque always lands in word zero.
					if (fill_level == 0) begin
						front_idx      = 0;
						rear_idx       = 0;
						deque_words[0] = r.value;
					end else if (r.op == OP_INS_FRONT) begin
						front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
						deque_words[front_idx] = r.value;
					end else begin
						rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
						deque_words[rear_idx] = r.value;
					end
					fill_level++;
				end
			end
			default: begin
				if (fill_level == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data = (r.op == OP_REM_FRONT) ? deque_words[front_idx]
						: deque_words[rear_idx];
					if (fill_level == 1) begin
						front_idx = 0;
						rear_idx  = 0;
					end else if (r.op == OP_REM_FRONT) begin
						front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
					end else begin
						rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
					end
					fill_level--;
				end
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t due;
		if (!arst_n) begin
			front_idx  = 0;
			rear_idx   = 0;
			fill_level = 0;
			predicted_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp_q.size() == 0) begin
					error_tally++;
					$display("%0t: response with none expected, actual data %0d status %0d",
						$time, rsp.data, rsp.status);
				end else begin
					due = predicted_rsp_q.pop_front();
					if (rsp.data !== due.data) begin
						error_tally++;
						$display("%0t: data mismatch, expected %0d, actual %0d",
							$time, due.data, rsp.data);
					end
					if (rsp.status !== due.status) begin
						error_tally++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, due.status, rsp.status);
					end
				end
			end
			if (req_valid && !req_stall)
				predicted_rsp_q.push_back(predict_response(req));
			outstanding <= predicted_rsp_q.size();
		end
	end

endmodule

/* test/tb_circular_deque.sv */
// ----------------------------------------------------------------------------
// tb_circular_deque
// Testbench for the circular deque.
// ----------------------------------------------------------------------------
// A directed pass covers empty and full refusals, pointer wrap at both ends,
// removal of the last element and extreme values. Random phases then favor
// filling, draining or a mix, with random idle bursts on both channels, a long
// response hold-off and a pause until all responses are in. Checking is done
// by cdq_response_check.
// ----------------------------------------------------------------------------

module tb_circular_deque;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int DEPTH        = 4;
	localparam int RANDOM_ITEMS = 650;
	localparam int TAIL_ITEMS   = 100;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	in_t         req       = '0;
	logic        rsp_stall = 1'b0;
	logic        req_stall;
	logic        rsp_valid;
	out_t        rsp;
	int          fail_count;
	int          outstanding;
	logic        idle_on   = 1'b0;
	logic        long_hold = 1'b0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	circular_deque #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	cdq_response_check #(.DEPTH(DEPTH)) response_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Offers one request, after an optional idle burst, and waits for it to be taken.
	task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
		in_t item;
		int  gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.op    = op;
		item.value = value;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// The extra edge lets the count of waiting responses take in the last request.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int                mode;
		int                seg_len;
		int                insert_pct;
		int                sent;
		logic [1:0]        op;
		logic [DATA_W-1:0] value;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Refusals on an empty deque, with a nonzero value that must be ignored.
		send_request(OP_REM_FRONT, 32'h1234_5678);
		send_request(OP_REM_REAR, 32'hFFFF_FFFF);
		// Fill from both ends so the front wraps below zero, then overfill.
		send_request(OP_INS_REAR, 32'h7FFF_FFFF);
		send_request(OP_INS_FRONT, 32'h8000_0000);
		send_request(OP_INS_REAR, 32'h0000_0000);
		send_request(OP_INS_FRONT, 32'hFFFF_FFFF);
		send_request(OP_INS_REAR, 32'h0000_0005);
		send_request(OP_INS_FRONT, 32'h0000_0006);
		// Drain from alternating ends down to empty and one past it.
		send_request(OP_REM_FRONT, 32'h0);
		send_request(OP_REM_REAR, 32'h0);
		send_request(OP_REM_FRONT, 32'h0);
		send_request(OP_REM_REAR, 32'h0);
		send_request(OP_REM_REAR, 32'h0);
		// Front insert into empty, then remove the only element.
		send_request(OP_INS_FRONT, 32'hA5A5_5A5A);
		send_request(OP_REM_FRONT, 32'h0);
		// Rear fill, then move the window so the rear wraps past the last word.
		send_request(OP_INS_REAR, 32'h5555_5555);
		send_request(OP_INS_REAR, 32'hAAAA_AAAA);
		send_request(OP_INS_REAR, 32'h0F0F_0F0F);
		send_request(OP_INS_REAR, 32'hF0F0_F0F0);
		send_request(OP_REM_FRONT, 32'h0);
		send_request(OP_REM_FRONT, 32'h0);
		send_request(OP_INS_REAR, 32'h0000_0001);
		send_request(OP_REM_REAR, 32'h0);
		send_request(OP_REM_REAR, 32'h0);
		send_request(OP_REM_FRONT, 32'h0);
		wait_drained();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode    = $urandom_range(0, 2);
			seg_len = $urandom_range(10, 40);
			idle_on = ($urandom_range(0, 3) != 0);
			case (mode)
				0:       insert_pct = 70;
				1:       insert_pct = 30;
				default: insert_pct = 50;
			endcase
			for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
				if (sent >= RANDOM_ITEMS - TAIL_ITEMS)
					idle_on = 1'b0;
				if (sent == 200)
					long_hold = 1'b1;
				if (sent == 400)
					wait_drained();
				if ($urandom_range(0, 99) < insert_pct)
					op = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
				else
					op = $urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT;
				case ($urandom_range(0, 7))
					0:       value = 32'h7FFF_FFFF;
					1:       value = 32'h8000_0000;
					2:       value = 32'h0000_0000;
					3:       value = 32'hFFFF_FFFF;
					default: value = $urandom;
				endcase
				send_request(op, value);
				sent++;
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
